// ===== hdl/seven_segment_scan_driver_defines.svh =====
`ifndef SEVEN_SEGMENT_SCAN_DRIVER_DEFINES_SVH
`define SEVEN_SEGMENT_SCAN_DRIVER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SSD_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SSD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ssd_pkg.sv =====
`default_nettype none

package ssd_pkg;

    localparam int VALUE_W  = 14;
    localparam int DIGIT_W  = 4;
    localparam int INDEX_W  = 3;
    localparam int BYTE_W   = 8;
    localparam int PROD_W   = 2 * VALUE_W;
    localparam int POINT_BIT = 5;

    localparam logic [VALUE_W-1:0] VALUE_MAX  = 14'd9999;
    localparam logic [DIGIT_W-1:0] DASH_ENTRY = 4'd10;

    // reciprocal multipliers for constant division of values up to 9999
    localparam logic [VALUE_W-1:0] RECIP_1000 = 14'd8389;
    localparam int                 SHIFT_1000 = 23;
    localparam logic [VALUE_W-1:0] RECIP_100  = 14'd10486;
    localparam int                 SHIFT_100  = 20;
    localparam logic [VALUE_W-1:0] RECIP_10   = 14'd13108;
    localparam int                 SHIFT_10   = 17;

    // digit position within a group of four
    localparam logic [1:0] POS_THOUSANDS = 2'd0;
    localparam logic [1:0] POS_HUNDREDS  = 2'd1;
    localparam logic [1:0] POS_TENS      = 2'd2;
    localparam logic [1:0] POS_UNITS     = 2'd3;

    typedef struct packed {
        logic [VALUE_W-1:0] quot;
        logic               dash;
        logic               point;
        logic [BYTE_W-1:0]  status;
        logic [INDEX_W-1:0] idx;
    } ssd_item_t;

    function automatic logic [BYTE_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] entry);
        logic [BYTE_W-1:0] pat;
        case (entry)
            4'd0:    pat = 8'b11010111;
            4'd1:    pat = 8'b00010100;
            4'd2:    pat = 8'b11001101;
            4'd3:    pat = 8'b01011101;
            4'd4:    pat = 8'b00011110;
            4'd5:    pat = 8'b01011011;
            4'd6:    pat = 8'b11011011;
            4'd7:    pat = 8'b00010101;
            4'd8:    pat = 8'b11011111;
            4'd9:    pat = 8'b01011111;
            default: pat = 8'b00001000;
        endcase
        return pat;
    endfunction

    function automatic logic [BYTE_W-1:0] select_pattern(input logic [INDEX_W-1:0] idx);
        logic [BYTE_W-1:0] pat;
        case (idx)
            3'd0:    pat = 8'h80;
            3'd1:    pat = 8'h40;
            3'd2:    pat = 8'h20;
            3'd3:    pat = 8'h10;
            3'd4:    pat = 8'h02;
            3'd5:    pat = 8'h04;
            3'd6:    pat = 8'h08;
            default: pat = 8'h01;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ssd_front.sv =====
`default_nettype none

module ssd_front
    import ssd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [VALUE_W-1:0] upper_value,
    input  wire logic [VALUE_W-1:0] lower_value,
    input  wire logic [BYTE_W-1:0]  point_mask,
    input  wire logic               dash_all,
    input  wire logic [BYTE_W-1:0]  status_leds,
    input  wire logic               item_take,
    output logic                    item_valid,
    output ssd_item_t               item
);

    logic [INDEX_W-1:0] scan_index_reg;
    logic [INDEX_W-1:0] scan_index_next;
    logic               item_valid_reg;
    logic               item_valid_next;
    ssd_item_t          item_reg;
    ssd_item_t          item_next;

    logic               accept;
    logic [VALUE_W-1:0] upper_sat;
    logic [VALUE_W-1:0] lower_sat;
    logic [VALUE_W-1:0] value;
    logic [PROD_W-1:0]  prod_1000;
    logic [PROD_W-1:0]  prod_100;
    logic [PROD_W-1:0]  prod_10;
    logic [VALUE_W-1:0] quot;

    assign in_ready = !item_valid_reg || item_take;
    assign accept   = in_valid && in_ready;

    // clamp to four decimal digits
    assign upper_sat = (upper_value > VALUE_MAX) ? VALUE_MAX : upper_value;
    assign lower_sat = (lower_value > VALUE_MAX) ? VALUE_MAX : lower_value;
    assign value     = scan_index_reg[2] ? lower_sat : upper_sat;

    assign prod_1000 = PROD_W'(value) * PROD_W'(RECIP_1000);
    assign prod_100  = PROD_W'(value) * PROD_W'(RECIP_100);
    assign prod_10   = PROD_W'(value) * PROD_W'(RECIP_10);

    always_comb
    begin
        case (scan_index_reg[1:0])
            POS_THOUSANDS: quot = VALUE_W'(prod_1000 >> SHIFT_1000);
            POS_HUNDREDS:  quot = VALUE_W'(prod_100 >> SHIFT_100);
            POS_TENS:      quot = VALUE_W'(prod_10 >> SHIFT_10);
            default:       quot = value;
        endcase
    end

    always_comb
    begin
        item_next.quot   = quot;
        item_next.dash   = dash_all;
        item_next.point  = point_mask[scan_index_reg];
        item_next.status = status_leds;
        item_next.idx    = scan_index_reg;

        scan_index_next = accept ? scan_index_reg + 1'b1 : scan_index_reg;

        if (accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (item_take)
        begin
            item_valid_next = 1'b0;
        end
        else
        begin
            item_valid_next = item_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_index_reg <= '0;
            item_valid_reg <= 1'b0;
        end
        else
        begin
            scan_index_reg <= scan_index_next;
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ===== hdl/ssd_encode.sv =====
`default_nettype none

module ssd_encode
    import ssd_pkg::*;
(
    input  wire ssd_item_t          item,
    output logic [BYTE_W-1:0]       segment,
    output logic [BYTE_W-1:0]       select
);

    logic [PROD_W-1:0]  prod;
    logic [VALUE_W-1:0] tens;
    logic [VALUE_W-1:0] rem;
    logic [DIGIT_W-1:0] entry;
    logic [BYTE_W-1:0]  point_bits;

    // quotient modulo ten
    assign prod  = PROD_W'(item.quot) * PROD_W'(RECIP_10);
    assign tens  = VALUE_W'(prod >> SHIFT_10);
    assign rem   = item.quot - ((tens << 3) + (tens << 1));
    assign entry = item.dash ? DASH_ENTRY : rem[DIGIT_W-1:0];

    assign point_bits = BYTE_W'(item.point) << POINT_BIT;
    assign segment    = seg_pattern(entry) | point_bits;
    assign select     = select_pattern(item.idx);

endmodule

`default_nettype wire

// ===== hdl/seven_segment_scan_driver.sv =====
// Eight-digit multiplexed seven-segment scan driver.
// Input channel (in_valid/in_ready): one word per refresh tick carrying two
// values of 0 to 9999 (upper group on digits 0-3, lower on 4-7, most
// significant first), eight decimal-point bits, a dash-all flag and a status
// byte. Values above 9999 show as 9999.
// Output channel (out_valid/out_ready): one word per input word with the
// segment byte of the current digit (point at bit 5), the one-hot select
// byte and the status byte.
// Each accepted word shows the next digit; the scan index wraps after 7.
// The word is caught in the input register at the accepting edge, and the result
// register loads from it on a later edge that the receiver allows. Throughput is
// one word per cycle: both registers reload on every edge the receiver allows,
// with only short multiply-and-shift logic for the digit split on each side of
// the input register.
// Reset clears the scan index to digit 0 and empties both registers.
// While out_ready is low the result holds; one more word is taken into the
// input register, after which in_ready falls until the result is taken.
`default_nettype none

`include "seven_segment_scan_driver_defines.svh"

module seven_segment_scan_driver
    import ssd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [VALUE_W-1:0] upper_value,
    input  wire logic [VALUE_W-1:0] lower_value,
    input  wire logic [BYTE_W-1:0]  point_mask,
    input  wire logic               dash_all,
    input  wire logic [BYTE_W-1:0]  status_leds,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [BYTE_W-1:0]       segment_byte,
    output logic [BYTE_W-1:0]       select_byte,
    output logic [BYTE_W-1:0]       status_byte
);

    logic              item_valid;
    ssd_item_t         item;
    logic              out_load;
    logic              item_take;
    logic [BYTE_W-1:0] segment;
    logic [BYTE_W-1:0] select;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] segment_reg;
    logic [BYTE_W-1:0] select_reg;
    logic [BYTE_W-1:0] status_reg;

    assign out_load  = !out_valid_reg || out_ready;
    assign item_take = item_valid && out_load;

    ssd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .upper_value (upper_value),
        .lower_value (lower_value),
        .point_mask  (point_mask),
        .dash_all    (dash_all),
        .status_leds (status_leds),
        .item_take   (item_take),
        .item_valid  (item_valid),
        .item        (item)
    );

    ssd_encode u_encode (
        .item    (item),
        .segment (segment),
        .select  (select)
    );

    always_comb
    begin
        if (item_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            segment_reg <= segment;
            select_reg  <= select;
            status_reg  <= item.status;
        end
    end

    assign out_valid    = out_valid_reg;
    assign segment_byte = segment_reg;
    assign select_byte  = select_reg;
    assign status_byte  = status_reg;

    `SSD_ASSERT_NOW(a_select_onehot, out_valid, $onehot(select_byte), "select byte not one-hot")
    `SSD_ASSERT_NEXT(a_accept_fills, in_valid && in_ready, item_valid, "accepted word lost")
    `SSD_ASSERT_NEXT(a_item_held, item_valid && !out_load, item_valid && $stable(item), "stalled word changed")

endmodule

`default_nettype wire

// ===== tb/sv/seven_segment_scan_driver_tb.sv =====
`timescale 1ns / 1ps

module seven_segment_scan_driver_tb
    import ssd_pkg::*;
();

    localparam int RANDOM_WORDS = 1000;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 8;

    // digit patterns, entry 0 in the low byte, dash last
    localparam logic [11*BYTE_W-1:0] DIGIT_SEGMENTS = {
        8'h08, 8'h5F, 8'hDF, 8'h15, 8'hDB, 8'h5B,
        8'h1E, 8'h5D, 8'hCD, 8'h14, 8'hD7
    };
    // one-hot digit selects, index 0 in the low byte
    localparam logic [8*BYTE_W-1:0] DIGIT_SELECTS = {
        8'h01, 8'h08, 8'h04, 8'h02, 8'h10, 8'h20, 8'h40, 8'h80
    };

    typedef struct packed {
        logic [VALUE_W-1:0] upper;
        logic [VALUE_W-1:0] lower;
        logic [BYTE_W-1:0]  points;
        logic               dash;
        logic [BYTE_W-1:0]  status;
    } tick_t;

    typedef struct packed {
        logic [BYTE_W-1:0] seg;
        logic [BYTE_W-1:0] sel;
        logic [BYTE_W-1:0] status;
    } digit_word_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [VALUE_W-1:0] upper_value = '0;
    logic [VALUE_W-1:0] lower_value = '0;
    logic [BYTE_W-1:0]  point_mask = '0;
    logic               dash_all = 1'b0;
    logic [BYTE_W-1:0]  status_leds = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [BYTE_W-1:0]  segment_byte;
    logic [BYTE_W-1:0]  select_byte;
    logic [BYTE_W-1:0]  status_byte;

    logic [INDEX_W-1:0] scan_pos = '0;
    digit_word_t        digits_due[$];
    logic               cur_typed = 1'b0;
    digit_word_t        cur_typed_word = '0;

    tick_t              table_ticks[$];
    logic               table_typed[$];
    digit_word_t        table_words[$];

    int unsigned        cycles = 0;
    int unsigned        errors = 0;
    int unsigned        words_sent = 0;
    int unsigned        digits_checked = 0;
    int unsigned        dash_words = 0;
    int unsigned        clipped_words = 0;

    int unsigned        stall_mode = 0;
    int unsigned        stall_left = 0;
    logic [7:0]         stall_mask = 8'hFF;

    seven_segment_scan_driver i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .upper_value  (upper_value),
        .lower_value  (lower_value),
        .point_mask   (point_mask),
        .dash_all     (dash_all),
        .status_leds  (status_leds),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .segment_byte (segment_byte),
        .select_byte  (select_byte),
        .status_byte  (status_byte)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic digit_word_t show_next_digit(input tick_t t);
        logic [VALUE_W-1:0] v;
        int unsigned        digit;
        digit_word_t        w;
        v = (scan_pos < 4) ? t.upper : t.lower;
        if (v > VALUE_MAX)
            v = VALUE_MAX;
        case (scan_pos[1:0])
            POS_THOUSANDS: digit = v / 1000;
            POS_HUNDREDS:  digit = (v % 1000) / 100;
            POS_TENS:      digit = (v % 100) / 10;
            default:       digit = v % 10;
        endcase
        if (t.dash)
            digit = DASH_ENTRY;
        w.seg = DIGIT_SEGMENTS[digit*BYTE_W +: BYTE_W];
        w.seg[POINT_BIT] = w.seg[POINT_BIT] | t.points[scan_pos];
        w.sel = DIGIT_SELECTS[scan_pos*BYTE_W +: BYTE_W];
        w.status = t.status;
        scan_pos = scan_pos + 1'b1;
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] got,
                                   input logic [BYTE_W-1:0] want);
        $display("mismatch at cycle %0d: %s got %02h expected %02h", cycles, what, got, want);
        errors++;
    endtask

    // outputs first, so an older word always sits at the head of the queue
    always @(posedge clk)
    begin
        digit_word_t due;
        digit_word_t predicted;
        tick_t       t;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (digits_due.size() == 0)
                    report_mismatch("segment_byte with no word pending", segment_byte, 8'h00);
                else
                begin
                    due = digits_due.pop_front();
                    if (segment_byte !== due.seg)
                        report_mismatch("segment_byte", segment_byte, due.seg);
                    if (select_byte !== due.sel)
                        report_mismatch("select_byte", select_byte, due.sel);
                    if (status_byte !== due.status)
                        report_mismatch("status_byte", status_byte, due.status);
                    digits_checked++;
                end
            end
            if (in_valid && in_ready)
            begin
                t = '{upper_value, lower_value, point_mask, dash_all, status_leds};
                predicted = show_next_digit(t);
                digits_due.push_back(cur_typed ? cur_typed_word : predicted);
                if (dash_all)
                    dash_words++;
                if (upper_value > VALUE_MAX || lower_value > VALUE_MAX)
                    clipped_words++;
            end
        end
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding", cycles,
                     digits_due.size());
            $display("seven_segment_scan_driver regression: fail");
            $finish;
        end
    end

    // receiver stalls: spells of always ready, coin toss, fixed mask, mostly stalled
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 120);
            stall_mask = 8'($urandom_range(1, 255));
        end
        stall_left--;
        case (stall_mode)
            0:       out_ready = 1'b1;
            1:       out_ready = 1'($urandom_range(0, 1));
            2:       out_ready = stall_mask[cycles % 8];
            default: out_ready = ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic send_word(input tick_t t, input logic typed, input digit_word_t w);
        in_valid = 1'b1;
        upper_value = t.upper;
        lower_value = t.lower;
        point_mask = t.points;
        dash_all = t.dash;
        status_leds = t.status;
        cur_typed = typed;
        cur_typed_word = w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic go_idle(input int unsigned n);
        if (n > 0)
        begin
            in_valid = 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic add_row(input int unsigned up, input int unsigned lo, input int unsigned pts,
                           input int unsigned dash, input int unsigned stat, input logic typed,
                           input int unsigned seg, input int unsigned sel);
        table_ticks.push_back('{up[VALUE_W-1:0], lo[VALUE_W-1:0], pts[BYTE_W-1:0], dash[0],
                                stat[BYTE_W-1:0]});
        table_typed.push_back(typed);
        table_words.push_back('{seg[BYTE_W-1:0], sel[BYTE_W-1:0], stat[BYTE_W-1:0]});
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return VALUE_W'($urandom_range(10000, 16383));
            1:       return ($urandom_range(0, 1) == 0) ? 14'd9999 : 14'd16383;
            2:       return VALUE_W'($urandom_range(0, 9));
            default: return VALUE_W'($urandom_range(0, 9999));
        endcase
    endfunction

    initial
    begin
        tick_t       t;
        digit_word_t none;
        int unsigned burst;
        none = '0;

        // digits 0 to 7 from reset: extremes, clipping, dash with and without point
        add_row(9999,  0,     8'h00, 0, 8'h00, 1'b1, 8'h5F, 8'h80);
        add_row(9999,  0,     8'h02, 0, 8'hFF, 1'b1, 8'h7F, 8'h40);
        add_row(16383, 0,     8'h00, 0, 8'hA5, 1'b1, 8'h5F, 8'h20);
        add_row(16383, 0,     8'hFF, 0, 8'h5A, 1'b1, 8'h7F, 8'h10);
        add_row(0,     0,     8'h00, 0, 8'h01, 1'b1, 8'hD7, 8'h02);
        add_row(0,     16383, 8'h00, 0, 8'h80, 1'b1, 8'h5F, 8'h04);
        add_row(0,     0,     8'h00, 1, 8'h00, 1'b1, 8'h08, 8'h08);
        add_row(0,     0,     8'h80, 1, 8'hFF, 1'b1, 8'h28, 8'h01);
        // every digit value at least once
        add_row(1234,  0,     8'h55, 0, 8'h3C, 1'b0, 0, 0);
        add_row(1234,  0,     8'h55, 0, 8'h3C, 1'b0, 0, 0);
        add_row(1234,  0,     8'h55, 0, 8'h3C, 1'b0, 0, 0);
        add_row(1234,  0,     8'h55, 0, 8'h3C, 1'b0, 0, 0);
        add_row(0,     5678,  8'hAA, 0, 8'hC3, 1'b0, 0, 0);
        add_row(0,     5678,  8'hAA, 0, 8'hC3, 1'b0, 0, 0);
        add_row(0,     5678,  8'hAA, 0, 8'hC3, 1'b0, 0, 0);
        add_row(0,     5678,  8'hAA, 0, 8'hC3, 1'b0, 0, 0);
        add_row(9012,  16383, 8'h0F, 0, 8'h96, 1'b0, 0, 0);
        add_row(9012,  16383, 8'h0F, 0, 8'h96, 1'b0, 0, 0);
        add_row(9012,  16383, 8'h0F, 0, 8'h96, 1'b0, 0, 0);
        add_row(9012,  16383, 8'h0F, 0, 8'h96, 1'b0, 0, 0);
        // just above range on the lower group, dash with points
        add_row(16383, 10000, 8'hF0, 0, 8'h69, 1'b0, 0, 0);
        add_row(16383, 10000, 8'hF0, 0, 8'h69, 1'b0, 0, 0);
        add_row(16383, 10000, 8'hF0, 1, 8'h69, 1'b0, 0, 0);
        add_row(16383, 10000, 8'hF0, 0, 8'h69, 1'b0, 0, 0);

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (table_ticks[i])
        begin
            send_word(table_ticks[i], table_typed[i], table_words[i]);
            if (i % 6 == 5)
                go_idle($urandom_range(0, 3));
        end

        burst = 0;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == RANDOM_WORDS / 2)
            begin
                in_valid = 1'b0;
                while (digits_due.size() != 0)
                    @(negedge clk);
            end
            if (burst == 0)
            begin
                burst = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0)
                    go_idle($urandom_range(1, 6));
            end
            burst--;
            t.upper = pick_value();
            t.lower = pick_value();
            t.points = BYTE_W'($urandom_range(0, 255));
            t.dash = ($urandom_range(0, 7) == 0);
            t.status = BYTE_W'($urandom_range(0, 255));
            send_word(t, 1'b0, none);
        end
        in_valid = 1'b0;

        while (digits_due.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("%0d words sent (%0d from the table), %0d digits checked, %0d mismatches",
                 words_sent, table_ticks.size(), digits_checked, errors);
        $display("%0d words with dash on, %0d with a value clipped to 9999, %0d cycles",
                 dash_words, clipped_words, cycles);
        if (errors == 0)
            $display("seven_segment_scan_driver regression: pass");
        else
            $display("seven_segment_scan_driver regression: fail");
        $finish;
    end

endmodule
